### hdl/qou_pkg.sv
// Shared types and constants of the quaternion orientation unit.
package qou_pkg;

    // Operation codes of a request.
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_MUL  = 3'd1;
    localparam logic [2:0] OP_ADDV = 3'd2;
    localparam logic [2:0] OP_NORM = 3'd3;
    localparam logic [2:0] OP_CONJ = 3'd4;
    localparam logic [2:0] OP_READ = 3'd5;

    // Sign of each Hamilton product term, indexed by component*4 + left index.
    localparam logic [15:0] HAM_NEG = 16'b0100_0010_1000_1110;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] N_SVEC = 5'd3;
    localparam logic [CNT_W-1:0] N_PROD = 5'd16;
    localparam logic [CNT_W-1:0] N_MAG  = 5'd4;

    typedef struct packed {
        logic en;
        logic first;
        logic neg;
    } t_mac_ctl;

    typedef struct packed {
        logic start;
        logic sqrt;
    } t_div_ctl;

endpackage

### hdl/qou_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
module qou_mac #(
    parameter int CW = 32,
    parameter int AW = 68
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  qou_pkg::t_mac_ctl      i_ctl,
    input  logic signed [CW-1:0]   i_a,
    input  logic signed [CW-1:0]   i_b,
    output logic signed [AW-1:0]   o_acc
);
    import qou_pkg::*;

    logic signed [2*CW-1:0] r_p;
    logic                   r_v;
    logic                   r_first;
    logic                   r_neg;
    logic signed [AW-1:0]   r_acc;
    logic signed [AW-1:0]   pe;
    logic signed [AW-1:0]   base;

    assign pe   = $signed({{(AW-2*CW){r_p[2*CW-1]}}, r_p});
    assign base = r_first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_ctl.en;
        end
        r_p     <= i_a * i_b;
        r_first <= i_ctl.first;
        r_neg   <= i_ctl.neg;
        if (r_v) begin
            r_acc <= r_neg ? base - pe : base + pe;
        end
    end

    assign o_acc = r_acc;
endmodule

### hdl/qou_rootdiv.sv
// Shared restoring unit: integer square root or unsigned division, one digit a cycle.
module qou_rootdiv #(
    parameter int RW = 33,
    parameter int NW = 57
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  qou_pkg::t_div_ctl        i_ctl,
    input  logic [((2*RW > NW) ? 2*RW : NW)-1:0] i_x,
    input  logic [RW-1:0]            i_d,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [((2*RW > NW) ? 2*RW : NW)-1:0] o_res
);
    import qou_pkg::*;

    localparam int XW  = (2*RW > NW) ? 2*RW : NW;
    localparam int RMW = RW + 3;
    localparam int SW  = $clog2(XW + 1);

    logic           r_busy;
    logic           r_done;
    logic           r_sqrt;
    logic [SW-1:0]  r_cnt;
    logic [XW-1:0]  r_x;
    logic [XW-1:0]  r_res;
    logic [RMW-1:0] r_rem;
    logic [RW-1:0]  r_d;
    logic [RMW-1:0] shifted;
    logic [RMW-1:0] trial;
    logic           ge;

    always_comb begin
        if (r_sqrt) begin
            shifted = {r_rem[RMW-3:0], r_x[XW-1:XW-2]};
            trial   = {1'b0, r_res[RW-1:0], 2'b01};
        end else begin
            shifted = {r_rem[RMW-2:0], r_x[XW-1]};
            trial   = {3'b000, r_d};
        end
        ge = (shifted >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_ctl.sqrt;
                r_cnt  <= i_ctl.sqrt ? SW'(RW) : SW'(NW);
                r_x    <= i_x;
                r_d    <= i_d;
                r_rem  <= '0;
                r_res  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? shifted - trial : shifted;
                r_res <= {r_res[XW-2:0], ge};
                r_x   <= r_sqrt ? (r_x << 2) : (r_x << 1);
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

### hdl/quaternion_orientation_unit.sv
// Top level of the quaternion orientation unit: sequencer, state and output register.
//
// Holds one quaternion (w, i, j, k) in signed fixed point (Q8.24 by default) and
// applies one request at a time: load, right-multiply, integrate a scaled vector,
// normalize, conjugate or read. Each request yields one result: the stored
// quaternion, its squared magnitude and a clip flag.
// Input channel: i_valid / o_stall; a request is taken when i_valid is high and
// o_stall low. o_stall is high from the cycle after a request is taken until its
// result is placed in the output register.
// Output channel: o_valid / i_stall; the output register holds its result while
// i_stall is high, and the next request is already taken meanwhile.
// Steps of a request; products go through the single shared multiplier (one product a cycle, two stages):
//   load, conjugate, read: magnitude only; multiply: sixteen products, then magnitude;
//   integrate: three scale products, sixteen products, magnitude;
//   normalize: magnitude, then root and four divisions in the digit-serial
//   root and divide unit, then magnitude again;
//   a zero quaternion on normalize sets w to one and measures again.
// The next request is taken only after the result of the last one is registered.
// Reset (synchronous, active low) clears the quaternion to zero and empties the
// output register.
module quaternion_orientation_unit #(
    parameter int COMPONENT_WIDTH = 32,
    parameter int FRACTION_BITS   = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_op,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_w,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_i,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_j,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_k,
    input  logic signed [COMPONENT_WIDTH-1:0] i_scale,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [COMPONENT_WIDTH-1:0] o_q_w,
    output logic signed [COMPONENT_WIDTH-1:0] o_q_i,
    output logic signed [COMPONENT_WIDTH-1:0] o_q_j,
    output logic signed [COMPONENT_WIDTH-1:0] o_q_k,
    output logic [COMPONENT_WIDTH-2:0]        o_mag_sq,
    output logic                              o_saturated
);
    import qou_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int RW = CW + 1;                 // root and divisor width
    localparam int MW = 2 * RW;                 // sum of squares width
    localparam int NW = CW + FB + 1;            // divide numerator width
    localparam int XW = (MW > NW) ? MW : NW;
    localparam int AW = (NW + 2 > 2*CW + 4) ? NW + 2 : 2*CW + 4;

    localparam logic signed [AW-1:0] MAXA = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] MINA = ~MAXA;
    localparam logic signed [AW-1:0] ONE_A   = AW'(1) << FB;
    localparam logic signed [AW-1:0] HALF_0  = AW'(1) << (FB-1);
    localparam logic signed [AW-1:0] HALF_1  = AW'(1) << FB;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SVEC = 3'd1;
    localparam logic [2:0] S_PROD = 3'd2;
    localparam logic [2:0] S_MAG  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    function automatic logic f_over(input logic signed [AW-1:0] x);
        return (x > MAXA) || (x < MINA);
    endfunction

    function automatic logic [CW-1:0] f_sat(input logic signed [AW-1:0] x);
        if (x > MAXA) return MAXA[CW-1:0];
        if (x < MINA) return MINA[CW-1:0];
        return x[CW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] f_ext(input logic signed [CW-1:0] v);
        return $signed({{(AW-CW){v[CW-1]}}, v});
    endfunction

    logic [2:0]             r_state;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [CW-1:0]   r_a [4];
    logic signed [CW-1:0]   r_scale;
    logic signed [CW-1:0]   r_q [4];
    logic signed [CW-1:0]   r_s [4];
    logic signed [CW-1:0]   r_n [4];
    logic [MW-1:0]          r_m;
    logic [RW-1:0]          r_r;
    logic [1:0]             r_c;
    logic                   r_norm;
    logic                   r_int;
    logic                   r_flag;
    logic                   r_wb1_v;
    logic [1:0]             r_wb1_d;
    logic                   r_wb2_v;
    logic [1:0]             r_wb2_d;
    logic                   r_ovalid;

    // Issue side of the shared multiplier.
    logic [3:0]             t;
    logic [1:0]             tc;
    logic [1:0]             tk;
    t_mac_ctl               mac_ctl;
    logic signed [CW-1:0]   mac_a;
    logic signed [CW-1:0]   mac_b;
    logic                   iss_last;
    logic [1:0]             iss_dst;
    logic [CNT_W-1:0]       end_cnt;
    logic                   phase_end;
    logic signed [AW-1:0]   acc;
    logic signed [AW-1:0]   rnd0;
    logic signed [AW-1:0]   wb_val;
    logic signed [AW-1:0]   mag_r;

    // Root and divide unit.
    t_div_ctl               div_ctl;
    logic [XW-1:0]          div_x;
    logic [RW-1:0]          div_d;
    logic                   div_busy;
    logic                   div_done;
    logic [XW-1:0]          div_res;
    logic [1:0]             nc;
    logic [CW-1:0]          mag_n;
    logic [NW-1:0]          num;
    logic [NW-1:0]          qv;
    logic signed [AW-1:0]   q_signed;

    logic                   accept;
    logic                   out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_ovalid || !i_stall;

    assign t  = r_cnt[3:0];
    assign tc = t[3:2];
    assign tk = t[1:0];

    always_comb begin
        mac_ctl  = '0;
        mac_a    = r_q[tk];
        mac_b    = r_q[tk];
        iss_last = 1'b0;
        iss_dst  = 2'd0;
        end_cnt  = N_MAG + 5'd2;
        unique case (r_state)
            S_SVEC: begin
                end_cnt       = N_SVEC + 5'd2;
                mac_ctl.en    = (r_cnt < N_SVEC);
                mac_ctl.first = 1'b1;
                mac_a         = r_a[2'(tk + 2'd1)];
                mac_b         = r_scale;
                iss_last      = 1'b1;
                iss_dst       = 2'(tk + 2'd1);
            end
            S_PROD: begin
                end_cnt       = N_PROD + 5'd2;
                mac_ctl.en    = (r_cnt < N_PROD);
                mac_ctl.first = (tk == 2'd0);
                mac_ctl.neg   = HAM_NEG[t];
                mac_a         = r_int ? r_s[tk] : r_q[tk];
                mac_b         = r_int ? r_q[tk ^ tc] : r_a[tk ^ tc];
                iss_last      = (tk == 2'd3);
                iss_dst       = tc;
            end
            S_MAG: begin
                mac_ctl.en    = (r_cnt < N_MAG);
                mac_ctl.first = (tk == 2'd0);
                iss_last      = (tk == 2'd3);
            end
            default: begin
            end
        endcase
        iss_last  = iss_last && mac_ctl.en;
        phase_end = (r_cnt == end_cnt);
    end

    qou_mac #(.CW(CW), .AW(AW)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    // Round to nearest, ties up; integrate adds half the product to the old value.
    assign rnd0   = (acc + HALF_0) >>> FB;
    assign wb_val = r_int ? f_ext(r_q[r_wb2_d]) + ((acc + HALF_1) >>> (FB + 1)) : rnd0;
    assign mag_r  = ($signed(AW'(r_m)) + HALF_0) >>> FB;

    // Next divide: component 0 right after the root, then the following one.
    always_comb begin
        nc       = (r_state == S_SQRT) ? 2'd0 : 2'(r_c + 2'd1);
        div_d    = (r_state == S_SQRT) ? div_res[RW-1:0] : r_r;
        mag_n    = r_q[nc][CW-1] ? (~r_q[nc] + 1'b1) : r_q[nc];
        num      = (NW'(mag_n) << FB) + NW'(div_d >> 1);
        div_ctl.sqrt  = (r_state == S_MAG);
        div_ctl.start = (r_state == S_MAG && phase_end && r_norm && r_m != '0)
                     || (r_state == S_SQRT && div_done)
                     || (r_state == S_DIV && div_done && r_c != 2'd3);
        div_x    = div_ctl.sqrt ? (XW'(r_m) << (XW - MW)) : (XW'(num) << (XW - NW));
        qv       = div_res[NW-1:0];
        q_signed = r_q[r_c][CW-1] ? -$signed(AW'(qv)) : $signed(AW'(qv));
    end

    qou_rootdiv #(.RW(RW), .NW(NW)) u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_x     (div_x),
        .i_d     (div_d),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_wb1_v  <= 1'b0;
            r_wb2_v  <= 1'b0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < 4; c++) begin
                r_q[c] <= '0;
            end
        end else begin
            // Writeback pipeline follows the two multiplier stages.
            r_wb1_v <= iss_last;
            r_wb1_d <= iss_dst;
            r_wb2_v <= r_wb1_v;
            r_wb2_d <= r_wb1_d;

            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            if (r_wb2_v) begin
                unique case (r_state)
                    S_SVEC: begin
                        r_s[r_wb2_d] <= f_sat(rnd0);
                        r_flag       <= r_flag | f_over(rnd0);
                    end
                    S_PROD: begin
                        r_n[r_wb2_d] <= f_sat(wb_val);
                        r_flag       <= r_flag | f_over(wb_val);
                    end
                    S_MAG: begin
                        r_m <= acc[MW-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a[0]  <= i_a_w;
                        r_a[1]  <= i_a_i;
                        r_a[2]  <= i_a_j;
                        r_a[3]  <= i_a_k;
                        r_scale <= i_scale;
                        r_s[0]  <= '0;
                        r_cnt   <= '0;
                        r_flag  <= 1'b0;
                        r_norm  <= 1'b0;
                        r_int   <= 1'b0;
                        r_state <= S_MAG;
                        unique case (i_op)
                            OP_LOAD: begin
                                r_q[0] <= i_a_w;
                                r_q[1] <= i_a_i;
                                r_q[2] <= i_a_j;
                                r_q[3] <= i_a_k;
                            end
                            OP_MUL: begin
                                r_state <= S_PROD;
                            end
                            OP_ADDV: begin
                                r_int   <= 1'b1;
                                r_state <= S_SVEC;
                            end
                            OP_NORM: begin
                                r_norm <= 1'b1;
                            end
                            OP_CONJ: begin
                                // Negate the vector part; the most negative value clips.
                                for (int c = 1; c < 4; c++) begin
                                    r_q[c] <= f_sat(-f_ext(r_q[c]));
                                end
                                r_flag <= f_over(-f_ext(r_q[1])) | f_over(-f_ext(r_q[2]))
                                        | f_over(-f_ext(r_q[3]));
                            end
                            default: begin
                                // Read and the unused codes leave the stored quaternion as it is.
                            end
                        endcase
                    end
                end
                S_SVEC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (phase_end) begin
                        r_cnt   <= '0;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (phase_end) begin
                        for (int c = 0; c < 4; c++) begin
                            r_q[c] <= r_n[c];
                        end
                        r_cnt   <= '0;
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (phase_end) begin
                        r_cnt <= '0;
                        if (!r_norm) begin
                            r_state <= S_OUT;
                        end else if (r_m == '0) begin
                            // Zero quaternion: set w to one and measure again.
                            r_q[0]  <= f_sat(ONE_A);
                            r_flag  <= r_flag | f_over(ONE_A);
                            r_norm  <= 1'b0;
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (div_done) begin
                        r_r     <= div_res[RW-1:0];
                        r_c     <= 2'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        // Later components are still read raw; overwrite this one now.
                        r_q[r_c] <= f_sat(q_signed);
                        r_flag   <= r_flag | f_over(q_signed);
                        r_c      <= 2'(r_c + 2'd1);
                        if (r_c == 2'd3) begin
                            r_norm  <= 1'b0;
                            r_cnt   <= '0;
                            r_state <= S_MAG;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        o_q_w       <= r_q[0];
                        o_q_i       <= r_q[1];
                        o_q_j       <= r_q[2];
                        o_q_k       <= r_q[3];
                        o_mag_sq    <= mag_r[CW-2:0] | {(CW-1){f_over(mag_r)}};
                        o_saturated <= r_flag | f_over(mag_r);
                        r_ovalid    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> !div_busy)
        else $error("root/divide unit started while busy");
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("request taken without holding off the next one");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROD) |-> (r_cnt <= N_PROD + 5'd2))
        else $error("product counter ran past its phase");
`endif
endmodule
